[hdl/mmcrc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register indexes and CRC mode tables for the selectable CRC block.
package mmcrc_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_CRC_MODE     = 2'd0,
    REG_CHECK_ENABLE = 2'd1,
    REG_BYTE_ORDER   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_NONE      = 3'd0,
    MODE_CCITT     = 3'd1,
    MODE_AUG_CCITT = 3'd2,
    MODE_CCITT_REV = 3'd3,
    MODE_AX25      = 3'd4,
    MODE_IBM       = 3'd5,
    MODE_CRC32C    = 3'd6
  } mode_e;

  localparam logic [15:0] POLY_CCITT     = 16'h1021;
  localparam logic [15:0] POLY_CCITT_REV = 16'h8408;
  localparam logic [15:0] POLY_IBM       = 16'h8005;
  localparam logic [31:0] POLY_CRC32C    = 32'h82F63B78;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_16   = 3'd2;
  localparam logic [2:0] LEN_32   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] crc_value;
    logic [2:0]  crc_length;
    logic        crc_ok;
    logic        frame_short;
  } out_item_t;

  // Configuration seen by the datapath. The restart flag pulses for one cycle
  // after a write to the mode or check-enable register.
  typedef struct packed {
    mode_e mode;
    logic  check_en;
    logic  byte_order;
    logic  restart;
  } cfg_t;

  function automatic logic [2:0] mode_len(mode_e m);
    logic [2:0] len;
    case (m)
      MODE_CCITT, MODE_AUG_CCITT, MODE_CCITT_REV, MODE_AX25, MODE_IBM: len = LEN_16;
      MODE_CRC32C: len = LEN_32;
      default: len = LEN_NONE;
    endcase
    return len;
  endfunction

  function automatic logic [31:0] mode_init(mode_e m);
    logic [31:0] v;
    case (m)
      MODE_AUG_CCITT: v = 32'h0000_1D0F;
      MODE_CCITT_REV, MODE_AX25, MODE_IBM: v = 32'h0000_FFFF;
      MODE_CRC32C: v = 32'hFFFF_FFFF;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] mode_xorout(mode_e m);
    logic [31:0] v;
    case (m)
      MODE_AUG_CCITT, MODE_CCITT_REV, MODE_AX25: v = 32'h0000_FFFF;
      MODE_CRC32C: v = 32'hFFFF_FFFF;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[hdl/mmcrc_byte_upd.sv]
`timescale 1ns / 1ps
// Byte-wide CRC update, unrolled over the eight bits of one byte.
module mmcrc_byte_upd (
  input  mmcrc_pkg::mode_e mode_i,
  input  logic [31:0]      crc_i,
  input  logic [7:0]       byte_i,
  output logic [31:0]      crc_o
);

  logic [15:0] r16;
  logic [31:0] r32;
  logic [15:0] poly16;

  always_comb begin
    r16    = 16'h0;
    r32    = 32'h0;
    poly16 = (mode_i == mmcrc_pkg::MODE_IBM) ? mmcrc_pkg::POLY_IBM : mmcrc_pkg::POLY_CCITT;
    crc_o  = 32'h0;
    case (mode_i)
      mmcrc_pkg::MODE_CCITT, mmcrc_pkg::MODE_AUG_CCITT, mmcrc_pkg::MODE_IBM: begin
        // MSB-first: the byte enters at the top of the register.
        r16 = crc_i[15:0] ^ {byte_i, 8'h00};
        for (int i = 0; i < 8; i++) begin
          r16 = r16[15] ? ({r16[14:0], 1'b0} ^ poly16) : {r16[14:0], 1'b0};
        end
        crc_o = {16'h0, r16};
      end
      mmcrc_pkg::MODE_CCITT_REV, mmcrc_pkg::MODE_AX25: begin
        r16 = crc_i[15:0] ^ {8'h00, byte_i};
        for (int i = 0; i < 8; i++) begin
          r16 = r16[0] ? ({1'b0, r16[15:1]} ^ mmcrc_pkg::POLY_CCITT_REV)
                       : {1'b0, r16[15:1]};
        end
        crc_o = {16'h0, r16};
      end
      mmcrc_pkg::MODE_CRC32C: begin
        r32 = crc_i ^ {24'h0, byte_i};
        for (int i = 0; i < 8; i++) begin
          r32 = r32[0] ? ({1'b0, r32[31:1]} ^ mmcrc_pkg::POLY_CRC32C)
                       : {1'b0, r32[31:1]};
        end
        crc_o = r32;
      end
      default: begin
        crc_o = 32'h0;
      end
    endcase
  end

endmodule

[hdl/mmcrc_regs.sv]
`timescale 1ns / 1ps
// APB-style configuration registers for the selectable CRC block.
module mmcrc_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mmcrc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mmcrc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mmcrc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready,
  output mmcrc_pkg::cfg_t                      cfg_o
);

  mmcrc_pkg::mode_e    mode_q;
  logic                check_en_q;
  logic                byte_order_q;
  logic                restart_q;
  logic                wr_en;
  mmcrc_pkg::reg_idx_e wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = mmcrc_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= mmcrc_pkg::MODE_NONE;
      check_en_q   <= 1'b0;
      byte_order_q <= 1'b0;
      restart_q    <= 1'b0;
    end else begin
      restart_q <= 1'b0;
      if (wr_en) begin
        case (wr_idx)
          mmcrc_pkg::REG_CRC_MODE: begin
            mode_q    <= mmcrc_pkg::mode_e'(pwdata[2:0]);
            restart_q <= 1'b1;
          end
          mmcrc_pkg::REG_CHECK_ENABLE: begin
            check_en_q <= pwdata[0];
            restart_q  <= 1'b1;
          end
          mmcrc_pkg::REG_BYTE_ORDER: begin
            byte_order_q <= pwdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (mmcrc_pkg::reg_idx_e'(paddr[3:2]))
      mmcrc_pkg::REG_CRC_MODE:     prdata = {29'h0, mode_q};
      mmcrc_pkg::REG_CHECK_ENABLE: prdata = {31'h0, check_en_q};
      mmcrc_pkg::REG_BYTE_ORDER:   prdata = {31'h0, byte_order_q};
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o.mode       = mode_q;
  assign cfg_o.check_en   = check_en_q;
  assign cfg_o.byte_order = byte_order_q;
  assign cfg_o.restart    = restart_q;

endmodule

[hdl/mmcrc_core.sv]
`timescale 1ns / 1ps
// Frame state, received-CRC delay line, comparison and result register.
module mmcrc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mmcrc_pkg::cfg_t      cfg_i,
  input  logic                 fire_i,
  input  mmcrc_pkg::in_item_t  item_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output mmcrc_pkg::out_item_t out_item_o
);

  logic [31:0]          crc_q, crc_d;
  logic [3:0][7:0]      held_q, held_d;
  logic [2:0]           seen_q, seen_d;
  logic                 out_valid_q;
  mmcrc_pkg::out_item_t out_item_q;
  mmcrc_pkg::out_item_t res;

  logic [2:0]  len;
  logic [7:0]  feed_byte;
  logic        do_feed;
  logic [31:0] crc_upd;
  logic [31:0] value;
  logic [31:0] recv;

  assign len = mmcrc_pkg::mode_len(cfg_i.mode);

  mmcrc_byte_upd u_byte_upd (
    .mode_i (cfg_i.mode),
    .crc_i  (crc_q),
    .byte_i (feed_byte),
    .crc_o  (crc_upd)
  );

  always_comb begin
    // In check mode the byte leaving the delay line is the one fed.
    feed_byte = item_i.data_byte;
    do_feed   = 1'b1;
    held_d    = held_q;
    if (cfg_i.check_en) begin
      feed_byte = (len == mmcrc_pkg::LEN_32) ? held_q[3] : held_q[1];
      do_feed   = (len != mmcrc_pkg::LEN_NONE) && (seen_q >= len);
      held_d    = {held_q[2:0], item_i.data_byte};
    end
    crc_d  = do_feed ? crc_upd : crc_q;
    seen_d = (seen_q != 3'd7) ? seen_q + 3'd1 : seen_q;

    value = (len == mmcrc_pkg::LEN_NONE) ? 32'h0 : (crc_d ^ mmcrc_pkg::mode_xorout(cfg_i.mode));
    if (len == mmcrc_pkg::LEN_16) begin
      value[31:16] = 16'h0;
    end

    // The first received CRC byte is the oldest one held.
    case (len)
      mmcrc_pkg::LEN_32: recv = cfg_i.byte_order ? {held_d[3], held_d[2], held_d[1], held_d[0]}
                                                 : {held_d[0], held_d[1], held_d[2], held_d[3]};
      mmcrc_pkg::LEN_16: recv = cfg_i.byte_order ? {16'h0, held_d[1], held_d[0]}
                                                 : {16'h0, held_d[0], held_d[1]};
      default:           recv = 32'h0;
    endcase

    res.crc_value   = value;
    res.crc_length  = len;
    res.crc_ok      = 1'b1;
    res.frame_short = 1'b0;
    if (cfg_i.check_en && (len != mmcrc_pkg::LEN_NONE)) begin
      if (seen_d < len) begin
        res.frame_short = 1'b1;
        res.crc_ok      = 1'b0;
      end else begin
        res.crc_ok = (recv == value);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= 32'h0;
      held_q      <= '0;
      seen_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.restart || (fire_i && item_i.last_byte)) begin
        crc_q  <= mmcrc_pkg::mode_init(cfg_i.mode);
        held_q <= '0;
        seen_q <= 3'd0;
      end else if (fire_i) begin
        crc_q  <= crc_d;
        held_q <= held_d;
        seen_q <= seen_d;
      end
      if (fire_i && item_i.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && item_i.last_byte) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hdl/multi_mode_crc_generate_check.sv]
`timescale 1ns / 1ps
// Top level of the selectable CRC generator and checker.
//
// Frame bytes enter on the input channel (in_valid_i / in_ready_o, payload
// in_item_i), one byte per item, with last_byte set on the final byte of a
// frame. One result item per frame leaves on the output channel
// (out_valid_o / out_ready_i, payload out_item_o); bytes that are not the
// last of a frame give no result. The APB-style port selects the CRC mode,
// generate or check operation, and the byte order of a received CRC.
// An accepted item is held in an input register; a frame's result is put
// in the result register as its last byte moves on. The block takes one
// item every cycle unless a last byte waits on a full result register; the
// byte-wide CRC update between the two registers is the longest path.
// If the receiver stalls, the finished result waits in the output register
// and further bytes keep flowing until another last byte reaches the head
// of the input register; only then does the input side stall.
// Reset clears the registers to mode none, generate operation, little-endian
// order, and starts a fresh frame. Writing the mode or check-enable register
// abandons any frame in progress; the new frame starts cleanly.
module multi_mode_crc_generate_check (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  mmcrc_pkg::in_item_t                  in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mmcrc_pkg::out_item_t                 out_item_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mmcrc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mmcrc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mmcrc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  mmcrc_pkg::cfg_t     cfg;
  logic                s1_valid_q;
  mmcrc_pkg::in_item_t s1_item_q;
  logic                advance;

  mmcrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A byte that closes a frame moves on only when the result register is
  // free or is being emptied in this cycle; all other bytes move on at once.
  assign advance    = s1_valid_q && (!s1_item_q.last_byte || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  mmcrc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (advance),
    .item_i      (s1_item_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
